/* hdl/cgde_pkg.sv */
// Shared types, register indexes and saturation helper for the generator evaluator.
package cgde_pkg;

  typedef logic signed [31:0] val_t;

  typedef enum logic [2:0] {
    REQ_RES  = 3'd0,
    REQ_FRES = 3'd1,
    REQ_CUR  = 3'd2,
    REQ_FJAC = 3'd3,
    REQ_DIDV = 3'd4,
    REQ_DFDV = 3'd5,
    REQ_DIDX = 3'd6,
    REQ_DFDX = 3'd7
  } req_e;

  localparam logic [2:0] CFG_EMF = 3'd0;
  localparam logic [2:0] CFG_PM  = 3'd1;
  localparam logic [2:0] CFG_IX  = 3'd2;
  localparam logic [2:0] CFG_IH  = 3'd3;
  localparam logic [2:0] CFG_DMP = 3'd4;
  localparam logic [2:0] CFG_IW  = 3'd5;

  typedef struct packed {
    req_e req;
    logic trig;
    val_t ang;
    val_t dw;
    val_t angr;
    val_t dwr;
    val_t vd;
    val_t vq;
    val_t shift;
    val_t accd;
    val_t accq;
  } item_t;

  typedef struct packed {
    logic signed [31:0] emf;
    logic signed [31:0] pm;
    logic [30:0]        ix;
    logic [30:0]        ih;
    logic signed [31:0] dmp;
    logic [30:0]        iw;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic row;
    logic col;
    val_t value;
    logic last;
  } res_t;

  function automatic val_t sat_val(input logic signed [65:0] v, input int unsigned bits);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = (66'sd1 <<< (bits - 1)) - 66'sd1;
    lo = -hi - 66'sd1;
    if (v > hi) begin
      return val_t'(hi);
    end else if (v < lo) begin
      return val_t'(lo);
    end
    return val_t'(v);
  endfunction

endpackage

/* hdl/cgde_front.sv */
// Front end: saturates and classifies an incoming request into a queue item.
module cgde_front #(
  parameter int SAT_BITS = 32
) (
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [2:0]          req_type_i,
  input  cgde_pkg::val_t      rotor_angle_i,
  input  cgde_pkg::val_t      speed_dev_i,
  input  cgde_pkg::val_t      angle_rate_i,
  input  cgde_pkg::val_t      speed_rate_i,
  input  cgde_pkg::val_t      volt_d_i,
  input  cgde_pkg::val_t      volt_q_i,
  input  cgde_pkg::val_t      jac_shift_i,
  input  cgde_pkg::val_t      cur_d_acc_i,
  input  cgde_pkg::val_t      cur_q_acc_i,
  output logic                push_o,
  output cgde_pkg::item_t     item_o
);
  import cgde_pkg::*;

  req_e req;

  assign req    = req_e'(req_type_i);
  assign push_o = start_i && !busy_i;

  always_comb begin
    item_o.req   = req;
    item_o.trig  = (req == REQ_RES) || (req == REQ_CUR) || (req == REQ_DFDV) ||
                   (req == REQ_DIDX) || (req == REQ_DFDX);
    item_o.ang   = sat_val(66'(rotor_angle_i), SAT_BITS);
    item_o.dw    = sat_val(66'(speed_dev_i), SAT_BITS);
    item_o.angr  = sat_val(66'(angle_rate_i), SAT_BITS);
    item_o.dwr   = sat_val(66'(speed_rate_i), SAT_BITS);
    item_o.vd    = sat_val(66'(volt_d_i), SAT_BITS);
    item_o.vq    = sat_val(66'(volt_q_i), SAT_BITS);
    item_o.shift = sat_val(66'(jac_shift_i), SAT_BITS);
    item_o.accd  = sat_val(66'(cur_d_acc_i), SAT_BITS);
    item_o.accq  = sat_val(66'(cur_q_acc_i), SAT_BITS);
  end

endmodule

/* hdl/cgde_fifo.sv */
// Two-entry item queue between front and back end.
module cgde_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cgde_pkg::item_t item_i,
  input  logic            pop_i,
  output cgde_pkg::item_t item_o,
  output logic            empty_o,
  output logic            full_o
);
  import cgde_pkg::*;

  item_t       mem_q [2];
  logic        wptr_q, wptr_d;
  logic        rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

/* hdl/cgde_cordic.sv */
// Iterative sine/cosine unit with exact range reduction modulo two pi.
module cgde_cordic #(
  parameter int FRAC_BITS = 16,
  parameter int SAT_BITS  = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  cgde_pkg::val_t ang_i,
  output logic           done_o,
  output cgde_pkg::val_t sin_o,
  output cgde_pkg::val_t cos_o
);
  import cgde_pkg::*;

  localparam int CQ    = 30;
  localparam int STEPS = 30;
  localparam int SH    = CQ - FRAC_BITS;
  localparam int RW    = 34 + SH;
  localparam int NQ    = SH + 1;
  localparam int KW    = (NQ > 1) ? $clog2(NQ) : 1;
  localparam int CW    = 36;

  localparam logic signed [RW-1:0] TWO_PI  = RW'(64'sd6746518852);
  localparam logic signed [RW-1:0] PI      = RW'(64'sd3373259426);
  localparam logic signed [RW-1:0] HALF_PI = RW'(64'sd1686629713);
  localparam logic signed [CW-1:0] GAIN    = CW'(64'sd652032874);
  localparam logic signed [65:0]   RNDC    = (SH > 0) ? (66'sd1 <<< (SH - 1)) : 66'sd0;

  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_RED   = 3'd1;
  localparam logic [2:0] C_FOLD1 = 3'd2;
  localparam logic [2:0] C_FOLD2 = 3'd3;
  localparam logic [2:0] C_ROT   = 3'd4;
  localparam logic [2:0] C_FIN   = 3'd5;

  function automatic logic signed [CW-1:0] atan_f(input logic [4:0] i);
    logic signed [31:0] a;
    case (i)
      5'd0:  a = 32'sd843314857;
      5'd1:  a = 32'sd497837829;
      5'd2:  a = 32'sd263043837;
      5'd3:  a = 32'sd133525159;
      5'd4:  a = 32'sd67021687;
      5'd5:  a = 32'sd33543516;
      5'd6:  a = 32'sd16775851;
      5'd7:  a = 32'sd8388437;
      5'd8:  a = 32'sd4194283;
      5'd9:  a = 32'sd2097149;
      default: a = 32'sd1 <<< (5'd30 - i);
    endcase
    return CW'(a);
  endfunction

  logic [2:0]             st_q;
  logic [KW-1:0]          k_q;
  logic [4:0]             i_q;
  logic                   neg_q;
  logic                   flip_q;
  logic signed [RW-1:0]   mag_q;
  logic signed [RW-1:0]   r_q;
  logic signed [CW-1:0]   x_q, y_q, z_q;
  logic                   done_q;
  val_t                   s_q, c_q;

  logic signed [RW-1:0]   r_in;
  logic signed [RW-1:0]   tp;
  logic signed [RW-1:0]   rem;
  logic signed [CW-1:0]   xs, ys;
  logic signed [65:0]     xr, yr;

  always_comb begin
    r_in = RW'(ang_i) <<< SH;
    tp   = TWO_PI <<< k_q;
    rem  = neg_q ? -mag_q : mag_q;
    xs   = x_q >>> i_q;
    ys   = y_q >>> i_q;
    xr   = (66'(x_q) + RNDC) >>> SH;
    yr   = (66'(y_q) + RNDC) >>> SH;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= C_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        C_IDLE: begin
          if (start_i) begin
            st_q <= C_RED;
          end
        end
        C_RED: begin
          if (k_q == '0) begin
            st_q <= C_FOLD1;
          end
        end
        C_FOLD1: st_q <= C_FOLD2;
        C_FOLD2: st_q <= C_ROT;
        C_ROT: begin
          if (i_q == 5'(STEPS - 1)) begin
            st_q <= C_FIN;
          end
        end
        C_FIN: begin
          st_q   <= C_IDLE;
          done_q <= 1'b1;
        end
        default: st_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      C_IDLE: begin
        neg_q <= (r_in < 0);
        mag_q <= (r_in < 0) ? -r_in : r_in;
        k_q   <= KW'(NQ - 1);
      end
      C_RED: begin
        if (mag_q >= tp) begin
          mag_q <= mag_q - tp;
        end
        k_q <= k_q - KW'(1);
      end
      C_FOLD1: begin
        if (rem > PI) begin
          r_q <= rem - TWO_PI;
        end else if (rem < -PI) begin
          r_q <= rem + TWO_PI;
        end else begin
          r_q <= rem;
        end
      end
      C_FOLD2: begin
        if (r_q > HALF_PI) begin
          z_q    <= CW'(r_q - PI);
          flip_q <= 1'b1;
        end else if (r_q < -HALF_PI) begin
          z_q    <= CW'(r_q + PI);
          flip_q <= 1'b1;
        end else begin
          z_q    <= CW'(r_q);
          flip_q <= 1'b0;
        end
        x_q <= GAIN;
        y_q <= '0;
        i_q <= 5'd0;
      end
      C_ROT: begin
        if (z_q >= 0) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_f(i_q);
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_f(i_q);
        end
        i_q <= i_q + 5'd1;
      end
      C_FIN: begin
        s_q <= sat_val(flip_q ? -yr : yr, SAT_BITS);
        c_q <= sat_val(flip_q ? -xr : xr, SAT_BITS);
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign sin_o  = s_q;
  assign cos_o  = c_q;

endmodule

/* hdl/cgde_back.sv */
// Back end: micro-sequenced multiply/add datapath that emits result entries.
module cgde_back #(
  parameter int FRAC_BITS = 16,
  parameter int SAT_BITS  = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cgde_pkg::cfg_t  cfg_i,
  input  cgde_pkg::item_t item_i,
  input  logic            empty_i,
  output logic            pop_o,
  output cgde_pkg::res_t  res_o
);
  import cgde_pkg::*;

  typedef enum logic [1:0] { K_MUL, K_ALU, K_EMIT } kind_e;

  typedef enum logic [4:0] {
    OP_ZERO, OP_ONE, OP_E, OP_S, OP_C, OP_ES, OP_EC, OP_ESX, OP_ECX, OP_IX, OP_NIX,
    OP_IH, OP_IW, OP_DW, OP_DMP, OP_VD, OP_VQ, OP_T, OP_M, OP_NESX, OP_ESVQ,
    OP_VDEC, OP_NSHIFT, OP_M_ANGR, OP_M_DWR, OP_ACCD_M, OP_ACCQ_M, OP_NSHIFT_M,
    OP_T0, OP_T7
  } op_e;

  localparam int NOPS = 30;

  typedef enum logic [2:0] { D_ES, D_EC, D_ESX, D_ECX, D_P1, D_P2, D_M, D_T } dst_e;

  typedef struct packed {
    kind_e kind;
    op_e   a;
    op_e   b;
    dst_e  dst;
    logic  row;
    logic  col;
    logic  last;
  } uop_t;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_TRIG = 2'd1;
  localparam logic [1:0] B_RUN  = 2'd2;

  localparam logic signed [65:0] RND = 66'sd1 <<< (FRAC_BITS - 1);

  function automatic uop_t mul_u(input op_e a, input op_e b, input dst_e d);
    uop_t u;
    u = '{kind: K_MUL, a: a, b: b, dst: d, row: 1'b0, col: 1'b0, last: 1'b0};
    return u;
  endfunction

  function automatic uop_t alu_u(input op_e a, input dst_e d);
    uop_t u;
    u = '{kind: K_ALU, a: a, b: OP_ZERO, dst: d, row: 1'b0, col: 1'b0, last: 1'b0};
    return u;
  endfunction

  function automatic uop_t emit_u(input op_e a, input logic r, input logic c,
                                  input logic l);
    uop_t u;
    u = '{kind: K_EMIT, a: a, b: OP_ZERO, dst: D_M, row: r, col: c, last: l};
    return u;
  endfunction

  function automatic uop_t uop_f(input req_e req, input logic [3:0] pc);
    uop_t u;
    u = emit_u(OP_ZERO, 1'b0, 1'b0, 1'b1);
    if (req == REQ_FRES || req == REQ_FJAC || req == REQ_DIDV) begin
      unique case (req)
        REQ_FRES: u = (pc == 4'd0) ? emit_u(OP_ZERO, 1'b0, 1'b0, 1'b0)
                                   : emit_u(OP_ZERO, 1'b1, 1'b0, 1'b1);
        REQ_FJAC: u = (pc == 4'd0) ? emit_u(OP_ONE, 1'b0, 1'b0, 1'b0)
                                   : emit_u(OP_ONE, 1'b1, 1'b1, 1'b1);
        default:  u = (pc == 4'd0) ? emit_u(OP_IX, 1'b0, 1'b0, 1'b0)
                                   : emit_u(OP_NIX, 1'b1, 1'b1, 1'b1);
      endcase
    end else if (pc < 4'd4) begin
      unique case (pc[1:0])
        2'd0: u = mul_u(OP_E, OP_S, D_ES);
        2'd1: u = mul_u(OP_E, OP_C, D_EC);
        2'd2: u = mul_u(OP_ES, OP_IX, D_ESX);
        default: u = mul_u(OP_EC, OP_IX, D_ECX);
      endcase
    end else begin
      case (req)
        REQ_RES: begin
          case (pc)
            4'd4:  u = mul_u(OP_DW, OP_IW, D_M);
            4'd5:  u = emit_u(OP_M_ANGR, 1'b0, 1'b0, 1'b0);
            4'd6:  u = mul_u(OP_VD, OP_ESX, D_P1);
            4'd7:  u = mul_u(OP_VQ, OP_ECX, D_P2);
            4'd8:  u = mul_u(OP_DMP, OP_DW, D_M);
            4'd9:  u = alu_u(OP_T0, D_T);
            4'd10: u = mul_u(OP_T, OP_IH, D_M);
            default: u = emit_u(OP_M_DWR, 1'b1, 1'b0, 1'b1);
          endcase
        end
        REQ_CUR: begin
          case (pc)
            4'd4:  u = mul_u(OP_ESVQ, OP_IX, D_M);
            4'd5:  u = emit_u(OP_ACCD_M, 1'b0, 1'b0, 1'b0);
            4'd6:  u = mul_u(OP_VDEC, OP_IX, D_M);
            default: u = emit_u(OP_ACCQ_M, 1'b1, 1'b0, 1'b1);
          endcase
        end
        REQ_DFDV: begin
          case (pc)
            4'd4:  u = mul_u(OP_NESX, OP_IH, D_M);
            4'd5:  u = emit_u(OP_M, 1'b1, 1'b0, 1'b0);
            4'd6:  u = mul_u(OP_ECX, OP_IH, D_M);
            default: u = emit_u(OP_M, 1'b1, 1'b1, 1'b1);
          endcase
        end
        REQ_DIDX: begin
          case (pc)
            4'd4:  u = emit_u(OP_ESX, 1'b0, 1'b0, 1'b0);
            default: u = emit_u(OP_ECX, 1'b1, 1'b0, 1'b1);
          endcase
        end
        default: begin
          case (pc)
            4'd4:  u = emit_u(OP_NSHIFT, 1'b0, 1'b0, 1'b0);
            4'd5:  u = emit_u(OP_IW, 1'b0, 1'b1, 1'b0);
            4'd6:  u = mul_u(OP_VD, OP_ECX, D_P1);
            4'd7:  u = mul_u(OP_VQ, OP_ESX, D_M);
            4'd8:  u = alu_u(OP_T7, D_T);
            4'd9:  u = mul_u(OP_T, OP_IH, D_M);
            4'd10: u = emit_u(OP_M, 1'b1, 1'b0, 1'b0);
            4'd11: u = mul_u(OP_DMP, OP_IH, D_M);
            default: u = emit_u(OP_NSHIFT_M, 1'b1, 1'b1, 1'b1);
          endcase
        end
      endcase
    end
    return u;
  endfunction

  function automatic val_t sat_f(input logic signed [65:0] v);
    return sat_val(v, SAT_BITS);
  endfunction

  logic [1:0]          st_q;
  logic [3:0]          pc_q;
  logic                ph_q;
  item_t               cur_q;
  val_t                es_q, ec_q, esx_q, ecx_q, p1_q, p2_q, m_q, t_q;
  logic signed [63:0]  prod_q;
  logic                res_valid_q;
  logic                res_row_q;
  logic                res_col_q;
  val_t                res_value_q;
  logic                res_last_q;

  logic                cor_start;
  logic                cor_done;
  val_t                sin_v, cos_v;

  val_t                e, pm, ix, ih, dmp, iw;
  val_t                opv [NOPS];
  uop_t                u;
  val_t                va, vb;
  val_t                mres;
  val_t                wval;

  cgde_cordic #(
    .FRAC_BITS (FRAC_BITS),
    .SAT_BITS  (SAT_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .ang_i   (item_i.ang),
    .done_o  (cor_done),
    .sin_o   (sin_v),
    .cos_o   (cos_v)
  );

  assign pop_o     = (st_q == B_IDLE) && !empty_i;
  assign cor_start = pop_o && item_i.trig;

  always_comb begin
    e   = sat_f(66'(cfg_i.emf));
    pm  = sat_f(66'(cfg_i.pm));
    ix  = sat_f(66'(signed'({1'b0, cfg_i.ix})));
    ih  = sat_f(66'(signed'({1'b0, cfg_i.ih})));
    dmp = sat_f(66'(cfg_i.dmp));
    iw  = sat_f(66'(signed'({1'b0, cfg_i.iw})));

    opv[OP_ZERO]     = '0;
    opv[OP_ONE]      = sat_f(66'sd1 <<< FRAC_BITS);
    opv[OP_E]        = e;
    opv[OP_S]        = sin_v;
    opv[OP_C]        = cos_v;
    opv[OP_ES]       = es_q;
    opv[OP_EC]       = ec_q;
    opv[OP_ESX]      = esx_q;
    opv[OP_ECX]      = ecx_q;
    opv[OP_IX]       = ix;
    opv[OP_NIX]      = sat_f(-66'(ix));
    opv[OP_IH]       = ih;
    opv[OP_IW]       = iw;
    opv[OP_DW]       = cur_q.dw;
    opv[OP_DMP]      = dmp;
    opv[OP_VD]       = cur_q.vd;
    opv[OP_VQ]       = cur_q.vq;
    opv[OP_T]        = t_q;
    opv[OP_M]        = m_q;
    opv[OP_NESX]     = sat_f(-66'(esx_q));
    opv[OP_ESVQ]     = sat_f(66'(es_q) - 66'(cur_q.vq));
    opv[OP_VDEC]     = sat_f(66'(cur_q.vd) - 66'(ec_q));
    opv[OP_NSHIFT]   = sat_f(-66'(cur_q.shift));
    opv[OP_M_ANGR]   = sat_f(66'(m_q) - 66'(cur_q.angr));
    opv[OP_M_DWR]    = sat_f(66'(m_q) - 66'(cur_q.dwr));
    opv[OP_ACCD_M]   = sat_f(66'(cur_q.accd) + 66'(m_q));
    opv[OP_ACCQ_M]   = sat_f(66'(cur_q.accq) + 66'(m_q));
    opv[OP_NSHIFT_M] = sat_f(66'(sat_f(-66'(cur_q.shift))) - 66'(m_q));
    opv[OP_T0]       = sat_f(66'(sat_f(66'(sat_f(66'(pm) - 66'(p1_q))) + 66'(p2_q)))
                             - 66'(m_q));
    opv[OP_T7]       = sat_f(66'(sat_f(-66'(p1_q))) - 66'(m_q));

    u    = uop_f(cur_q.req, pc_q);
    va   = opv[u.a];
    vb   = opv[u.b];
    mres = sat_f((66'(prod_q) + RND) >>> FRAC_BITS);
    wval = (u.kind == K_MUL) ? mres : va;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      pc_q        <= 4'd0;
      ph_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (st_q)
        B_IDLE: begin
          pc_q <= 4'd0;
          ph_q <= 1'b0;
          if (!empty_i) begin
            st_q <= item_i.trig ? B_TRIG : B_RUN;
          end
        end
        B_TRIG: begin
          if (cor_done) begin
            st_q <= B_RUN;
          end
        end
        B_RUN: begin
          if (u.kind == K_MUL && !ph_q) begin
            ph_q <= 1'b1;
          end else begin
            ph_q <= 1'b0;
            pc_q <= pc_q + 4'd1;
            if (u.kind == K_EMIT) begin
              res_valid_q <= 1'b1;
              if (u.last) begin
                st_q <= B_IDLE;
              end
            end
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= item_i;
    end
    if (st_q == B_RUN) begin
      if (u.kind == K_MUL && !ph_q) begin
        prod_q <= 64'(va) * 64'(vb);
      end
      if (u.kind == K_EMIT) begin
        res_row_q   <= u.row;
        res_col_q   <= u.col;
        res_value_q <= va;
        res_last_q  <= u.last;
      end
      if ((u.kind == K_MUL && ph_q) || u.kind == K_ALU) begin
        case (u.dst)
          D_ES:    es_q  <= wval;
          D_EC:    ec_q  <= wval;
          D_ESX:   esx_q <= wval;
          D_ECX:   ecx_q <= wval;
          D_P1:    p1_q  <= wval;
          D_P2:    p2_q  <= wval;
          D_M:     m_q   <= wval;
          default: t_q   <= wval;
        endcase
      end
    end
  end

  assign res_o = '{valid: res_valid_q, row: res_row_q, col: res_col_q,
                   value: res_value_q, last: res_last_q};

endmodule

/* hdl/classical_generator_dae_eval.sv */
// Top level of the classical generator swing-equation evaluator.
//
//  channel   direction  handshake                 payload
//  request   in         start_i / busy_o          req_type_i .. cur_q_acc_i
//  result    out        result_valid_o (strobe)   entry_row_o .. last_entry_o
//  config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// The back end pops each item, then emits two entries directly for the fault and dI/dV
// requests. Requests that need sin/cos first wait on the iterative CORDIC (range
// reduction, two folds, 30 rotations, finish), then on the single shared multiplier,
// whose product is registered before the result is written back.
// A two-entry queue accepts new requests while the back end works; busy_o is high
// when the queue is full. Reset clears all control state and loads register defaults.
module classical_generator_dae_eval #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  req_type_i,
  input  logic signed [31:0] rotor_angle_i,
  input  logic signed [31:0] speed_dev_i,
  input  logic signed [31:0] angle_rate_i,
  input  logic signed [31:0] speed_rate_i,
  input  logic signed [31:0] volt_d_i,
  input  logic signed [31:0] volt_q_i,
  input  logic signed [31:0] jac_shift_i,
  input  logic signed [31:0] cur_d_acc_i,
  input  logic signed [31:0] cur_q_acc_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output logic        entry_row_o,
  output logic        entry_col_o,
  output logic signed [31:0] entry_value_o,
  output logic        last_entry_o
);
  import cgde_pkg::*;

  localparam int SAT_BITS = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  cfg_t  cfg_q;
  logic  push;
  item_t fr_item;
  item_t q_item;
  logic  q_empty;
  logic  q_full;
  logic  pop;
  res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.emf <= 32'sd65536;
      cfg_q.pm  <= 32'sd0;
      cfg_q.ix  <= 31'd65536;
      cfg_q.ih  <= 31'd65536;
      cfg_q.dmp <= 32'sd0;
      cfg_q.iw  <= 31'd174;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EMF: cfg_q.emf <= cfg_data_i;
        CFG_PM:  cfg_q.pm  <= cfg_data_i;
        CFG_IX:  cfg_q.ix  <= cfg_data_i[30:0];
        CFG_IH:  cfg_q.ih  <= cfg_data_i[30:0];
        CFG_DMP: cfg_q.dmp <= cfg_data_i;
        CFG_IW:  cfg_q.iw  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  cgde_front #(
    .SAT_BITS (SAT_BITS)
  ) u_front (
    .start_i       (start_i),
    .busy_i        (q_full),
    .req_type_i    (req_type_i),
    .rotor_angle_i (rotor_angle_i),
    .speed_dev_i   (speed_dev_i),
    .angle_rate_i  (angle_rate_i),
    .speed_rate_i  (speed_rate_i),
    .volt_d_i      (volt_d_i),
    .volt_q_i      (volt_q_i),
    .jac_shift_i   (jac_shift_i),
    .cur_d_acc_i   (cur_d_acc_i),
    .cur_q_acc_i   (cur_q_acc_i),
    .push_o        (push),
    .item_o        (fr_item)
  );

  cgde_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fr_item),
    .pop_i   (pop),
    .item_o  (q_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  cgde_back #(
    .FRAC_BITS (FRAC_BITS),
    .SAT_BITS  (SAT_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .item_i  (q_item),
    .empty_i (q_empty),
    .pop_o   (pop),
    .res_o   (res)
  );

  assign busy_o         = q_full;
  assign result_valid_o = res.valid;
  assign entry_row_o    = res.row;
  assign entry_col_o    = res.col;
  assign entry_value_o  = res.value;
  assign last_entry_o   = res.last;

endmodule
